>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that an antecedent is followed by a consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/piq_pkg.sv
// Package with the constants and types of the pending interrupt priority queue.
`timescale 1ns / 1ps
package piq_pkg;

  localparam int NUM_VECTORS = 256;
  localparam int VEC_W       = 8;
  localparam int LVL_W       = 8;
  localparam int VIDX_W      = $clog2(NUM_VECTORS);
  localparam int VCMP_W      = VEC_W + 1;

  localparam logic [LVL_W-1:0] FREE_LEVEL = 8'hFF;

  localparam logic [1:0] MODE_ALERT = 2'd0;
  localparam logic [1:0] MODE_TAKE  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  typedef struct packed {
    logic [1:0]       mode;
    logic [VEC_W-1:0] vector;
    logic [LVL_W-1:0] level;
  } in_item_t;

  typedef struct packed {
    logic             pending;
    logic [VEC_W-1:0] top_vector;
    logic [LVL_W-1:0] top_level;
  } out_item_t;

  typedef struct packed {
    logic             valid;
    logic [LVL_W-1:0] level;
    logic [VEC_W-1:0] vector;
  } entry_t;

  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [LVL_W-1:0] level;
    logic [VEC_W-1:0] vector;
  } cell_cmd_t;

endpackage

>>> hw/rtl/pending_interrupt_priority_queue.sv
// Top level of the pending interrupt priority queue: control, pending map and cell chain.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// An item is taken when start is high and busy is low. Its result appears
// on result with done high for one cycle, after the states EXEC and LOAD;
// the receiver cannot stall it, and the next item may be started in that
// same done cycle, but not while an item is in EXEC or LOAD. In EXEC the
// sorted chain of cells shifts every entry by at most one place, and in
// LOAD the head of the chain is registered. No clearing pass follows reset.
module pending_interrupt_priority_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  piq_pkg::in_item_t   request,
  output logic                done,
  output piq_pkg::out_item_t  result
);
  import piq_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;

  logic [1:0]             state;
  logic [1:0]             state_next;
  in_item_t               op;
  logic [NUM_VECTORS-1:0] pend;
  logic [NUM_VECTORS-1:0] pend_next;
  out_item_t              result_next;

  cell_cmd_t              cmd;
  entry_t                 chain   [NUM_VECTORS];
  logic                   ahead   [NUM_VECTORS];
  entry_t                 head;
  logic                   in_range;
  logic                   ins_ok;
  logic                   rem_ok;
  logic                   head_ordered;

  assign busy = (state != ST_IDLE);
  assign head = chain[0];

  assign in_range = ({1'b0, op.vector} < VCMP_W'(NUM_VECTORS));
  assign ins_ok   = (state == ST_EXEC) && (op.mode == MODE_ALERT) &&
                    (op.level != FREE_LEVEL) && in_range &&
                    !pend[op.vector[VIDX_W-1:0]];
  assign rem_ok   = (state == ST_EXEC) && (op.mode == MODE_TAKE) && head.valid;

  always_comb begin
    cmd.ins    = ins_ok;
    cmd.rem    = rem_ok;
    cmd.level  = op.level;
    cmd.vector = op.vector;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: state_next = ST_LOAD;
      ST_LOAD: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pend_next = pend;
    if (ins_ok) begin
      pend_next[op.vector[VIDX_W-1:0]] = 1'b1;
    end else if (rem_ok) begin
      pend_next[head.vector[VIDX_W-1:0]] = 1'b0;
    end
  end

  always_comb begin
    result_next = '0;
    if (head.valid) begin
      result_next.pending    = 1'b1;
      result_next.top_vector = head.vector;
      result_next.top_level  = head.level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pend  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
      done  <= (state == ST_LOAD);
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op <= request;
    end
    if (state == ST_LOAD) begin
      result <= result_next;
    end
  end

  // Cell zero sees an empty neighbor that always ranks ahead; the last cell
  // pulls in an empty entry on a removal.
  genvar i;
  generate
    for (i = 0; i < NUM_VECTORS; i++) begin : g_cell
      entry_t left_e;
      entry_t right_e;
      logic   left_a;
      if (i == 0) begin : g_first
        assign left_e = '0;
        assign left_a = 1'b1;
      end else begin : g_inner
        assign left_e = chain[i-1];
        assign left_a = ahead[i-1];
      end
      if (i == NUM_VECTORS - 1) begin : g_last
        assign right_e = '0;
      end else begin : g_body
        assign right_e = chain[i+1];
      end
      piq_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .cmd        (cmd),
        .left       (left_e),
        .left_ahead (left_a),
        .right      (right_e),
        .entry      (chain[i]),
        .ahead      (ahead[i])
      );
    end
  endgenerate

  assign head_ordered = !chain[1].valid ||
                        (chain[0].valid &&
                         ({chain[0].level, chain[0].vector} >
                          {chain[1].level, chain[1].vector}));

  `ASSERT_CLK(a_done_idle, !done || !busy, "result strobe while busy")
  `ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted item did not raise busy")
  `ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
  `ASSERT_CLK(a_chain_order, head_ordered, "chain head out of order")

endmodule

>>> hw/rtl/piq_cell.sv
// One cell of the sorted chain: holds one pending vector and its level.
`timescale 1ns / 1ps
module piq_cell (
  input  logic              clk,
  input  logic              rst,
  input  piq_pkg::cell_cmd_t cmd,
  input  piq_pkg::entry_t   left,
  input  logic              left_ahead,
  input  piq_pkg::entry_t   right,
  output piq_pkg::entry_t   entry,
  output logic              ahead
);
  import piq_pkg::*;

  logic             valid;
  logic [LVL_W-1:0] level;
  logic [VEC_W-1:0] vector;
  logic             valid_next;
  logic [LVL_W-1:0] level_next;
  logic [VEC_W-1:0] vector_next;

  always_comb begin
    entry.valid  = valid;
    entry.level  = level;
    entry.vector = vector;
  end

  // The chain is sorted with the most urgent entry in cell zero, so the
  // cells that rank above a new entry form a prefix of the chain.
  assign ahead = valid && ({level, vector} > {cmd.level, cmd.vector});

  always_comb begin
    valid_next  = valid;
    level_next  = level;
    vector_next = vector;
    if (cmd.ins) begin
      if (!ahead) begin
        if (left_ahead) begin
          valid_next  = 1'b1;
          level_next  = cmd.level;
          vector_next = cmd.vector;
        end else begin
          valid_next  = left.valid;
          level_next  = left.level;
          vector_next = left.vector;
        end
      end
    end else if (cmd.rem) begin
      valid_next  = right.valid;
      level_next  = right.level;
      vector_next = right.vector;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    level  <= level_next;
    vector <= vector_next;
  end

endmodule
